### src/u8d_pkg.sv
// u8d_pkg: shared types and constants for the utf-8 stream decoder
// used by every module under src; depends on nothing

package u8d_pkg;

    localparam int C_BYTE_W    = 8;
    localparam int C_PAY_W     = 6;
    localparam int C_CP_W      = 26;
    localparam int C_HELD_N    = 3;
    localparam int C_CNT_W     = 3;
    localparam int C_Q_DEPTH   = 4;
    localparam int C_Q_AW      = $clog2(C_Q_DEPTH);
    localparam int C_Q_CW      = $clog2(C_Q_DEPTH + 1);

    localparam logic [7:0] C_LEAD_MIN  = 8'hC0;
    localparam logic [1:0] C_CONT_TAG  = 2'b10;
    localparam logic [7:0] C_MASK_LEN2 = 8'h1F;
    localparam logic [7:0] C_MASK_LEN3 = 8'h0F;
    localparam logic [7:0] C_MASK_LEN4 = 8'h07;
    localparam logic [7:0] C_MASK_LEN5 = 8'h03;

    localparam logic [4:0] C_CLS_LEN2_MAX = 5'd27;
    localparam logic [4:0] C_CLS_LEN3_MAX = 5'd29;
    localparam logic [4:0] C_CLS_LEN4     = 5'd30;

    localparam logic [2:0] C_LEN2 = 3'd2;
    localparam logic [2:0] C_LEN3 = 3'd3;
    localparam logic [2:0] C_LEN4 = 3'd4;
    localparam logic [2:0] C_LEN5 = 3'd5;

    // one decoded request worth of results: raw flush run then optional tail
    typedef struct packed {
        logic [C_CNT_W-1:0]                  flush_n;
        logic [C_BYTE_W-1:0]                 lead;
        logic [C_HELD_N-1:0][C_PAY_W-1:0]    held;
        logic                                tail_v;
        logic [C_CP_W-1:0]                   tail_cp;
        logic                                tail_raw;
    } t_job;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [C_Q_CW-1:0] level;
    } t_q_stat;

endpackage

### src/utf8_stream_decoder.sv
// utf8_stream_decoder: top level of the byte-serial utf-8 decoder
// instantiates u8d_front, u8d_queue and u8d_back; depends on u8d_pkg
//
//  channel  | valid   | stall   | payload
//  ---------+---------+---------+-------------------------------------------
//  bytes in | i_valid | o_stall | i_data_byte, i_end_of_string
//  results  | o_valid | i_stall | o_code_point, o_raw_fallback, o_end_of_run
//
// one byte request per cycle while the four-entry job queue has room
// each byte yields zero to five results, sent one per cycle by the back end while the output is not stalled
// results pass through the job queue and then the output register on their way to the outputs
// reset clears sequence state, queue pointers and output valid
// an output stall holds the output register; the front keeps taking bytes
// until the job queue fills

module utf8_stream_decoder
    import u8d_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [C_BYTE_W-1:0] i_data_byte,
    input  logic                i_end_of_string,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [C_CP_W-1:0]   o_code_point,
    output logic                o_raw_fallback,
    output logic                o_end_of_run
);

    t_job    push_job;
    t_job    head_job;
    t_q_stat q_stat;
    logic    q_push;
    logic    q_pop;

    u8d_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_string (i_end_of_string),
        .i_q_stat        (q_stat),
        .o_push          (q_push),
        .o_job           (push_job)
    );

    u8d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    u8d_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (head_job),
        .i_q_stat       (q_stat),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_code_point   (o_code_point),
        .o_raw_fallback (o_raw_fallback),
        .o_end_of_run   (o_end_of_run)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("job pushed into full queue");

    a_job_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> ((push_job.flush_n != '0) || push_job.tail_v))
        else $error("job with no results queued");

    a_no_pop_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> !q_pop)
        else $error("job retired while output stalled");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.level <= C_Q_CW'(C_Q_DEPTH))
        else $error("queue level out of range");

endmodule

### src/u8d_front.sv
// u8d_front: accepts bytes, tracks the open sequence and classifies each request
// into a result job; depends on u8d_pkg

module u8d_front
    import u8d_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [C_BYTE_W-1:0] i_data_byte,
    input  logic                i_end_of_string,
    input  t_q_stat             i_q_stat,
    output logic                o_push,
    output t_job                o_job
);

    logic [C_BYTE_W-1:0]               r_lead, n_lead;
    logic [C_HELD_N-1:0][C_PAY_W-1:0]  r_held, n_held;
    logic [C_CNT_W-1:0]                r_exp, n_exp;
    logic [C_CNT_W-1:0]                r_rcv, n_rcv;
    logic [C_CP_W-1:0]                 r_partial, n_partial;

    logic               acc;
    logic               is_cont;
    logic               fall;
    logic [C_CNT_W-1:0] cnt_inc;
    logic [1:0]         idx;
    logic [4:0]         cls;
    t_job               job;

    assign o_stall = i_q_stat.full;
    assign acc     = i_valid && !i_q_stat.full;
    assign is_cont = (i_data_byte[7:6] == C_CONT_TAG);
    assign cnt_inc = r_rcv + 3'd1;
    assign idx     = 2'(r_rcv - 3'd1);
    assign cls     = i_data_byte[7:3];

    always_comb begin
        n_lead    = r_lead;
        n_held    = r_held;
        n_exp     = r_exp;
        n_rcv     = r_rcv;
        n_partial = r_partial;
        fall      = 1'b1;
        job          = '0;
        job.lead     = r_lead;
        job.held     = r_held;

        if (r_exp != '0) begin
            if (is_cont) begin
                fall      = 1'b0;
                n_partial = {r_partial[C_CP_W-C_PAY_W-1:0], i_data_byte[C_PAY_W-1:0]};
                n_rcv     = cnt_inc;
                if (cnt_inc >= r_exp) begin
                    job.tail_v   = 1'b1;
                    job.tail_cp  = n_partial;
                    job.tail_raw = 1'b0;
                    n_exp        = '0;
                    n_rcv        = '0;
                    n_partial    = '0;
                end else begin
                    n_held[idx] = i_data_byte[C_PAY_W-1:0];
                    job.held    = n_held;
                    if (i_end_of_string) begin
                        job.flush_n = cnt_inc;
                        n_exp       = '0;
                        n_rcv       = '0;
                        n_partial   = '0;
                    end
                end
            end else begin
                // interrupted: lead plus held continuation bytes go out raw
                job.flush_n = r_rcv;
                n_exp       = '0;
                n_rcv       = '0;
                n_partial   = '0;
            end
        end

        if (fall) begin
            if (i_data_byte >= C_LEAD_MIN) begin
                n_lead = i_data_byte;
                n_rcv  = 3'd1;
                priority if (cls <= C_CLS_LEN2_MAX) begin
                    n_exp     = C_LEN2;
                    n_partial = C_CP_W'(i_data_byte & C_MASK_LEN2);
                end else if (cls <= C_CLS_LEN3_MAX) begin
                    n_exp     = C_LEN3;
                    n_partial = C_CP_W'(i_data_byte & C_MASK_LEN3);
                end else if (cls == C_CLS_LEN4) begin
                    n_exp     = C_LEN4;
                    n_partial = C_CP_W'(i_data_byte & C_MASK_LEN4);
                end else begin
                    n_exp     = C_LEN5;
                    n_partial = C_CP_W'(i_data_byte & C_MASK_LEN5);
                end
                if (i_end_of_string) begin
                    job.tail_v   = 1'b1;
                    job.tail_cp  = C_CP_W'(i_data_byte);
                    job.tail_raw = 1'b1;
                    n_exp        = '0;
                    n_rcv        = '0;
                    n_partial    = '0;
                end
            end else begin
                job.tail_v   = 1'b1;
                job.tail_cp  = C_CP_W'(i_data_byte);
                job.tail_raw = i_data_byte[7];
            end
        end
    end

    assign o_job  = job;
    assign o_push = acc && ((job.flush_n != '0) || job.tail_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead    <= '0;
            r_exp     <= '0;
            r_rcv     <= '0;
            r_partial <= '0;
        end else if (acc) begin
            r_lead    <= n_lead;
            r_exp     <= n_exp;
            r_rcv     <= n_rcv;
            r_partial <= n_partial;
        end
    end

    // held payloads are only read after being written in the same sequence
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_held <= n_held;
        end
    end

endmodule

### src/u8d_queue.sv
// u8d_queue: short job queue between the byte front end and the result back end
// depends on u8d_pkg

module u8d_queue
    import u8d_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    t_job              r_mem [C_Q_DEPTH];
    logic [C_Q_AW-1:0] r_wp;
    logic [C_Q_AW-1:0] r_rp;
    logic [C_Q_CW-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == C_Q_CW'(C_Q_DEPTH));
    assign o_stat.level = r_cnt;
    assign o_job        = r_mem[r_rp];

    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

### src/u8d_back.sv
// u8d_back: walks the head job one result per cycle, while not stalled, into the output register
// depends on u8d_pkg

module u8d_back
    import u8d_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_job              i_job,
    input  t_q_stat           i_q_stat,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [C_CP_W-1:0] o_code_point,
    output logic              o_raw_fallback,
    output logic              o_end_of_run
);

    logic [C_CNT_W-1:0] r_idx, n_idx;
    logic               r_valid;
    logic [C_CP_W-1:0]  r_cp, n_cp;
    logic               r_raw, n_raw;
    logic               r_eor, n_eor;

    logic               load;
    logic               emit;
    logic [C_CNT_W-1:0] total;
    logic [1:0]         hidx;

    assign load  = !r_valid || !i_stall;
    assign emit  = load && !i_q_stat.empty;
    assign total = i_job.flush_n + C_CNT_W'(i_job.tail_v);
    assign hidx  = 2'(r_idx - 3'd1);

    always_comb begin
        if (r_idx < i_job.flush_n) begin
            n_raw = 1'b1;
            if (r_idx == '0) begin
                n_cp = C_CP_W'(i_job.lead);
            end else begin
                n_cp = C_CP_W'({C_CONT_TAG, i_job.held[hidx]});
            end
        end else begin
            n_raw = i_job.tail_raw;
            n_cp  = i_job.tail_cp;
        end
        n_eor = ((r_idx + 3'd1) == total);
        n_idx = n_eor ? '0 : r_idx + 3'd1;
    end

    assign o_pop = emit && n_eor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= emit;
            end
            if (emit) begin
                r_idx <= n_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_cp  <= n_cp;
            r_raw <= n_raw;
            r_eor <= n_eor;
        end
    end

    assign o_valid        = r_valid;
    assign o_code_point   = r_cp;
    assign o_raw_fallback = r_raw;
    assign o_end_of_run   = r_eor;

endmodule

### tb/sv/u8d_decode_checker.sv
`timescale 1ns / 1ps
// u8d_decode_checker: watches both channels of the utf-8 stream decoder, predicts
// the code points each byte request causes and compares them in order
// depends on u8d_pkg

module u8d_decode_checker
    import u8d_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [C_BYTE_W-1:0] i_data_byte,
    input  logic                i_end_of_string,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [C_CP_W-1:0]   i_code_point,
    input  logic                i_raw_fallback,
    input  logic                i_end_of_run,
    output int                  o_pending,
    output int                  o_fail_count,
    output int                  o_results,
    output int                  o_raw_results,
    output int                  o_sequences
);

    typedef struct packed {
        logic [C_CP_W-1:0] cp;
        logic              raw;
        logic              last;
    } t_code_point;

    t_code_point                code_points_due [$];

    logic [C_BYTE_W-1:0]        seq_lead;
    logic [C_PAY_W-1:0]         seq_held [C_HELD_N];
    logic [C_CNT_W-1:0]         seq_len;
    logic [C_CNT_W-1:0]         seq_seen;
    logic [C_CP_W-1:0]          seq_acc;

    int                         n_fail;
    int                         n_results;
    int                         n_raw;
    int                         n_seq;

    function automatic void push_code_point(input logic [C_CP_W-1:0] cp, input logic raw);
        t_code_point item;
        item.cp   = cp;
        item.raw  = raw;
        item.last = 1'b0;
        code_points_due.push_back(item);
    endfunction

    function automatic void close_seq();
        seq_len  = '0;
        seq_seen = '0;
        seq_acc  = '0;
    endfunction

    // open sequence goes out byte by byte, lead first
    function automatic void flush_open_seq();
        int n_held;
        n_held = (seq_seen > 1) ? int'(seq_seen) - 1 : 0;
        if (n_held > C_HELD_N) n_held = C_HELD_N;
        push_code_point(C_CP_W'(seq_lead), 1'b1);
        for (int i = 0; i < n_held; i++) begin
            push_code_point(C_CP_W'({C_CONT_TAG, seq_held[i]}), 1'b1);
        end
        close_seq();
    endfunction

    function automatic void decode_byte(input logic [C_BYTE_W-1:0] b, input logic eos);
        int          n_before;
        int          idx;
        bit          taken;
        logic [4:0]  cls;
        t_code_point tail;
        n_before = code_points_due.size();
        taken    = 1'b0;
        if (seq_len != '0) begin
            if (b[7:6] == C_CONT_TAG) begin
                seq_acc  = {seq_acc[C_CP_W-C_PAY_W-1:0], b[C_PAY_W-1:0]};
                seq_seen = seq_seen + 1'b1;
                if (seq_seen >= seq_len) begin
                    push_code_point(seq_acc, 1'b0);
                    close_seq();
                    n_seq++;
                end else begin
                    idx = int'(seq_seen) - 2;
                    if (idx < C_HELD_N) seq_held[idx] = b[C_PAY_W-1:0];
                    if (eos) flush_open_seq();
                end
                taken = 1'b1;
            end else begin
                flush_open_seq();
            end
        end
        if (!taken) begin
            if (b >= C_LEAD_MIN) begin
                cls = b[7:3];
                if (cls <= C_CLS_LEN2_MAX) begin
                    seq_len = C_LEN2;
                    seq_acc = C_CP_W'(b & C_MASK_LEN2);
                end else if (cls <= C_CLS_LEN3_MAX) begin
                    seq_len = C_LEN3;
                    seq_acc = C_CP_W'(b & C_MASK_LEN3);
                end else if (cls == C_CLS_LEN4) begin
                    seq_len = C_LEN4;
                    seq_acc = C_CP_W'(b & C_MASK_LEN4);
                end else begin
                    seq_len = C_LEN5;
                    seq_acc = C_CP_W'(b & C_MASK_LEN5);
                end
                seq_lead = b;
                seq_seen = C_CNT_W'(1);
                if (eos) flush_open_seq();
            end else begin
                push_code_point(C_CP_W'(b), b[7]);
            end
        end
        if (code_points_due.size() > n_before) begin
            tail = code_points_due[code_points_due.size() - 1];
            tail.last = 1'b1;
            code_points_due[code_points_due.size() - 1] = tail;
        end
    endfunction

    initial begin
        n_fail    = 0;
        n_results = 0;
        n_raw     = 0;
        n_seq     = 0;
        seq_lead  = '0;
        close_seq();
    end

    always @(posedge i_clk) begin
        t_code_point want;
        if (!i_rst_n) begin
            code_points_due.delete();
            seq_lead = '0;
            close_seq();
        end else begin
            if (i_in_valid && !i_in_stall) decode_byte(i_data_byte, i_end_of_string);
            if (i_out_valid && !i_out_stall) begin
                n_results++;
                if (i_raw_fallback) n_raw++;
                if (code_points_due.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("unexpected result: cp=%h raw=%b last=%b",
                                 i_code_point, i_raw_fallback, i_end_of_run);
                end else begin
                    want = code_points_due.pop_front();
                    if (i_code_point !== want.cp || i_raw_fallback !== want.raw
                            || i_end_of_run !== want.last) begin
                        n_fail++;
                        if (n_fail <= 10)
                            $display("result %0d mismatch: expected cp=%h raw=%b last=%b, got cp=%h raw=%b last=%b",
                                     n_results, want.cp, want.raw, want.last,
                                     i_code_point, i_raw_fallback, i_end_of_run);
                    end
                end
            end
        end
        o_pending     <= code_points_due.size();
        o_fail_count  <= n_fail;
        o_results     <= n_results;
        o_raw_results <= n_raw;
        o_sequences   <= n_seq;
    end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: drives byte requests into utf8_stream_decoder and stalls its output
// at random; checking is done by u8d_decode_checker; depends on u8d_pkg

module tb_top;
    import u8d_pkg::*;

    localparam int C_RANDOM_ITEMS = 420;
    localparam int C_LONG_HOLD    = 400;
    localparam int C_WATCHDOG     = 3000;
    localparam int C_TAIL_CYCLES  = 16;
    localparam int C_N_WARM       = 28;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [C_BYTE_W-1:0] i_data_byte;
    logic                i_end_of_string;
    logic                o_valid;
    logic                i_stall;
    logic [C_CP_W-1:0]   o_code_point;
    logic                o_raw_fallback;
    logic                o_end_of_run;

    int                  pending;
    int                  fail_count;
    int                  n_results;
    int                  n_raw;
    int                  n_seq;

    int                  n_sent;
    int                  burst_left;
    bit                  quiet;
    bit                  hold_go;
    int                  idle_cycles;

    // {end of string, byte}
    logic [8:0] warm_up [C_N_WARM] = '{
        9'h000, 9'h07F, 9'h080, 9'h0BF,
        9'h0E2, 9'h082, 9'h0AC,
        9'h0F0, 9'h09F, 9'h098, 9'h080,
        9'h0FF, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF,
        9'h0F8, 9'h080, 9'h080, 9'h080, 9'h041,
        9'h0F4, 9'h08F, 9'h0C0, 9'h080,
        9'h0E2, 9'h182,
        9'h1FC
    };

    utf8_stream_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_string (i_end_of_string),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_code_point    (o_code_point),
        .o_raw_fallback  (o_raw_fallback),
        .o_end_of_run    (o_end_of_run)
    );

    u8d_decode_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_string (i_end_of_string),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_code_point    (o_code_point),
        .i_raw_fallback  (o_raw_fallback),
        .i_end_of_run    (o_end_of_run),
        .o_pending       (pending),
        .o_fail_count    (fail_count),
        .o_results       (n_results),
        .o_raw_results   (n_raw),
        .o_sequences     (n_seq)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eos);
        i_valid         <= 1'b1;
        i_data_byte     <= b;
        i_end_of_string <= eos;
        do @(posedge i_clk); while (o_stall);
        n_sent++;
    endtask

    task automatic idle_for(input int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_results_in();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic put_byte(input logic [7:0] b, input logic eos);
        int g;
        send_byte(b, eos);
        if (burst_left > 0) begin
            burst_left--;
        end else if (!quiet) begin
            g = pick_gap();
            if (g > 0) idle_for(g);
        end
    endtask

    // output side: random stalls, free stretches and one long hold on request
    initial begin
        int  left;
        int  g;
        bit  level;
        i_stall <= 1'b0;
        left  = 0;
        level = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go) begin
                hold_go = 1'b0;
                level   = 1'b1;
                left    = C_LONG_HOLD;
            end else if (left == 0) begin
                if ($urandom_range(0, 9) == 0) begin
                    level = 1'b0;
                    left  = $urandom_range(40, 150);
                end else begin
                    g     = pick_gap();
                    level = (g > 0);
                    left  = (g > 0) ? g : $urandom_range(1, 6);
                end
            end
            i_stall <= level;
            left--;
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < C_WATCHDOG) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("timeout: no request moved for %0d cycles", C_WATCHDOG);
        $display("simulation failed");
        $finish;
    end

    initial begin
        int          rnd_start;
        int          kind;
        int          len;
        int          ncont;
        logic [7:0]  b;
        bit          hold_done;
        bit          paused;
        n_sent          = 0;
        burst_left      = 0;
        quiet           = 1'b0;
        hold_go         = 1'b0;
        hold_done       = 1'b0;
        paused          = 1'b0;
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_data_byte     <= '0;
        i_end_of_string <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < C_N_WARM; i++) put_byte(warm_up[i][7:0], warm_up[i][8]);
        wait_results_in();

        rnd_start = n_sent;
        while (n_sent - rnd_start < C_RANDOM_ITEMS) begin
            quiet = (((n_sent - rnd_start) / 50) % 4 == 2);
            if (!hold_done && n_sent - rnd_start >= 150) begin
                hold_done  = 1'b1;
                hold_go    = 1'b1;
                burst_left = 40;
            end
            if (!paused && n_sent - rnd_start >= 300) begin
                paused = 1'b1;
                wait_results_in();
            end
            kind = $urandom_range(0, 99);
            if (kind < 15) begin
                put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            end else begin
                len   = $urandom_range(1, 5);
                ncont = len - 1;
                if (len > 1 && $urandom_range(0, 99) < 15) ncont = $urandom_range(0, len - 2);
                case (len)
                    1: b = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(0, 8'h7F));
                    2: b = 8'($urandom_range(8'hC0, 8'hDF));
                    3: b = 8'($urandom_range(8'hE0, 8'hEF));
                    4: b = 8'($urandom_range(8'hF0, 8'hF7));
                    default: b = 8'($urandom_range(8'hF8, 8'hFF));
                endcase
                put_byte(b, (ncont == 0) && ($urandom_range(0, 7) == 0));
                for (int k = 1; k <= ncont; k++) begin
                    put_byte(8'h80 | 8'($urandom_range(0, 63)),
                             $urandom_range(0, (k == ncont) ? 7 : 29) == 0);
                end
            end
        end

        wait_results_in();
        repeat (C_TAIL_CYCLES) @(posedge i_clk);
        $display("%0d bytes in, %0d results out: %0d raw bytes, %0d completed sequences",
                 n_sent, n_results, n_raw, n_seq);
        $display("plain, orphan, all sequence lengths, interruptions, string-end flushes,");
        $display("%0d-cycle hold", C_LONG_HOLD);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
